[hw/rtl/vrts_pkg.sv]
`timescale 1ns / 1ps

package vrts_pkg;

    // configuration port
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 48;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROT_X    = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROT_Y    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROT_Z    = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFFSET_X = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFFSET_Y = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFFSET_Z = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCALE    = 3'd6;

    // register widths and reset values
    localparam int ROT_WIDTH   = 32;
    localparam int SCALE_WIDTH = 48;
    localparam logic [ROT_WIDTH-1:0]   ROT_RESET   = 32'h4000_0000;
    localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = 48'h0100_0100_0100;

    // fixed point formats
    localparam int TRIG_WIDTH  = 16;
    localparam int TRIG_FRAC   = 14;
    localparam int FACTOR_WIDTH = 16;
    localparam int FACTOR_FRAC = 8;

    // forward control that travels with each item
    typedef struct packed {
        logic valid;
        logic ovf;
    } ctl_t;

endpackage

[hw/rtl/vrts_rotate.sv]
`timescale 1ns / 1ps

// two-stage plane rotation: a' = c*a - s*b, b' = s*a + c*b, c passes through
module vrts_rotate #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [vrts_pkg::ROT_WIDTH-1:0]       cos_sin,
    input  vrts_pkg::ctl_t                       in_ctl,
    output logic                                 in_ready,
    input  logic signed [COORD_WIDTH-1:0]        in_a,
    input  logic signed [COORD_WIDTH-1:0]        in_b,
    input  logic signed [COORD_WIDTH-1:0]        in_c,
    output vrts_pkg::ctl_t                       out_ctl,
    input  logic                                 out_ready,
    output logic signed [COORD_WIDTH-1:0]        out_a,
    output logic signed [COORD_WIDTH-1:0]        out_b,
    output logic signed [COORD_WIDTH-1:0]        out_c
);

    localparam int PW = COORD_WIDTH + vrts_pkg::TRIG_WIDTH;
    localparam int QW = COORD_WIDTH + 3;
    localparam logic [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // saturate a floored sum; top bit of the result is the overflow mark
    function automatic logic [COORD_WIDTH:0] sat_q(input logic signed [QW-1:0] q);
        logic signed [COORD_WIDTH-1:0] low;
        logic                          fits;
        low  = q[COORD_WIDTH-1:0];
        fits = (QW'(low) == q);
        if (fits)
            return {1'b0, low};
        else if (q[QW-1])
            return {1'b1, CMIN};
        else
            return {1'b1, CMAX};
    endfunction

    logic signed [vrts_pkg::TRIG_WIDTH-1:0] c_coef;
    logic signed [vrts_pkg::TRIG_WIDTH-1:0] s_coef;

    vrts_pkg::ctl_t          ctl1_reg, ctl1_next;
    vrts_pkg::ctl_t          ctl2_reg, ctl2_next;
    logic signed [PW-1:0]    pca_reg, pca_next;
    logic signed [PW-1:0]    psb_reg, psb_next;
    logic signed [PW-1:0]    psa_reg, psa_next;
    logic signed [PW-1:0]    pcb_reg, pcb_next;
    logic signed [COORD_WIDTH-1:0] c1_reg;
    logic signed [COORD_WIDTH-1:0] a2_reg, a2_next;
    logic signed [COORD_WIDTH-1:0] b2_reg, b2_next;
    logic signed [COORD_WIDTH-1:0] c2_reg;
    logic signed [PW:0]      sum_a;
    logic signed [PW:0]      sum_b;
    logic [COORD_WIDTH:0]    sat_a;
    logic [COORD_WIDTH:0]    sat_b;
    logic                    en1;
    logic                    en2;

    // stage enables, bubbles collapse
    assign en2      = ~ctl2_reg.valid | out_ready;
    assign en1      = ~ctl1_reg.valid | en2;
    assign in_ready = en1;

    assign c_coef = cos_sin[31:16];
    assign s_coef = cos_sin[15:0];

    // stage 1: four products
    always_comb
    begin
        ctl1_next = in_ctl;
        pca_next  = in_a * c_coef;
        psb_next  = in_b * s_coef;
        psa_next  = in_a * s_coef;
        pcb_next  = in_b * c_coef;
    end

    // stage 2: exact sums, floor by 2^14, saturate
    always_comb
    begin
        sum_a          = {pca_reg[PW-1], pca_reg} - {psb_reg[PW-1], psb_reg};
        sum_b          = {psa_reg[PW-1], psa_reg} + {pcb_reg[PW-1], pcb_reg};
        sat_a          = sat_q(sum_a[PW:vrts_pkg::TRIG_FRAC]);
        sat_b          = sat_q(sum_b[PW:vrts_pkg::TRIG_FRAC]);
        a2_next        = sat_a[COORD_WIDTH-1:0];
        b2_next        = sat_b[COORD_WIDTH-1:0];
        ctl2_next.valid = ctl1_reg.valid;
        ctl2_next.ovf   = ctl1_reg.ovf | sat_a[COORD_WIDTH] | sat_b[COORD_WIDTH];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else
        begin
            if (en1)
                ctl1_reg <= ctl1_next;
            if (en2)
                ctl2_reg <= ctl2_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            pca_reg <= pca_next;
            psb_reg <= psb_next;
            psa_reg <= psa_next;
            pcb_reg <= pcb_next;
            c1_reg  <= in_c;
        end
        if (en2)
        begin
            a2_reg <= a2_next;
            b2_reg <= b2_next;
            c2_reg <= c1_reg;
        end
    end

    assign out_ctl = ctl2_reg;
    assign out_a   = a2_reg;
    assign out_b   = b2_reg;
    assign out_c   = c2_reg;

    // an accepted item lands in stage 1
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ctl.valid && in_ready) |=> ctl1_reg.valid)
        else $error("accepted item missing from first stage");

    // an overflow mark is never dropped on the way through
    a_ovf_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl1_reg.valid && ctl1_reg.ovf && en2) |=> ctl2_reg.ovf)
        else $error("overflow mark lost in rotation");

endmodule

[hw/rtl/vrts_offset_scale.sv]
`timescale 1ns / 1ps

// three-stage translate and scale: add offset, multiply, floor by 2^8
module vrts_offset_scale #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [COORD_WIDTH-1:0]               offset_x,
    input  logic [COORD_WIDTH-1:0]               offset_y,
    input  logic [COORD_WIDTH-1:0]               offset_z,
    input  logic [vrts_pkg::SCALE_WIDTH-1:0]     scale_xyz,
    input  vrts_pkg::ctl_t                       in_ctl,
    output logic                                 in_ready,
    input  logic signed [COORD_WIDTH-1:0]        in_x,
    input  logic signed [COORD_WIDTH-1:0]        in_y,
    input  logic signed [COORD_WIDTH-1:0]        in_z,
    output vrts_pkg::ctl_t                       out_ctl,
    input  logic                                 out_ready,
    output logic signed [COORD_WIDTH-1:0]        out_x,
    output logic signed [COORD_WIDTH-1:0]        out_y,
    output logic signed [COORD_WIDTH-1:0]        out_z
);

    localparam int FW = vrts_pkg::FACTOR_WIDTH;
    localparam int PW = COORD_WIDTH + FW;
    localparam int SW = COORD_WIDTH + 1;
    localparam int QW = PW - vrts_pkg::FACTOR_FRAC;
    localparam logic [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // saturate the offset sum; top bit is the overflow mark
    function automatic logic [COORD_WIDTH:0] sat_sum(input logic signed [SW-1:0] q);
        logic signed [COORD_WIDTH-1:0] low;
        low = q[COORD_WIDTH-1:0];
        if (SW'(low) == q)
            return {1'b0, low};
        else if (q[SW-1])
            return {1'b1, CMIN};
        else
            return {1'b1, CMAX};
    endfunction

    // saturate the floored product; top bit is the overflow mark
    function automatic logic [COORD_WIDTH:0] sat_prod(input logic signed [QW-1:0] q);
        logic signed [COORD_WIDTH-1:0] low;
        low = q[COORD_WIDTH-1:0];
        if (QW'(low) == q)
            return {1'b0, low};
        else if (q[QW-1])
            return {1'b1, CMIN};
        else
            return {1'b1, CMAX};
    endfunction

    logic signed [COORD_WIDTH-1:0] lane_in  [3];
    logic        [COORD_WIDTH-1:0] lane_off [3];
    logic signed [FW-1:0]          lane_fac [3];

    vrts_pkg::ctl_t                ctl1_reg, ctl1_next;
    vrts_pkg::ctl_t                ctl2_reg;
    vrts_pkg::ctl_t                ctl3_reg, ctl3_next;
    logic signed [COORD_WIDTH-1:0] v1_reg   [3];
    logic signed [COORD_WIDTH-1:0] v1_next  [3];
    logic signed [PW-1:0]          p2_reg   [3];
    logic signed [PW-1:0]          p2_next  [3];
    logic signed [COORD_WIDTH-1:0] v3_reg   [3];
    logic signed [COORD_WIDTH-1:0] v3_next  [3];
    logic signed [SW-1:0]          sum1     [3];
    logic [COORD_WIDTH:0]          sat1     [3];
    logic [COORD_WIDTH:0]          sat3     [3];
    logic                          en1;
    logic                          en2;
    logic                          en3;

    assign en3      = ~ctl3_reg.valid | out_ready;
    assign en2      = ~ctl2_reg.valid | en3;
    assign en1      = ~ctl1_reg.valid | en2;
    assign in_ready = en1;

    // lane wiring
    assign lane_in[0]  = in_x;
    assign lane_in[1]  = in_y;
    assign lane_in[2]  = in_z;
    assign lane_off[0] = offset_x;
    assign lane_off[1] = offset_y;
    assign lane_off[2] = offset_z;
    assign lane_fac[0] = scale_xyz[47:32];
    assign lane_fac[1] = scale_xyz[31:16];
    assign lane_fac[2] = scale_xyz[15:0];

    // stage 1: add offset and saturate
    always_comb
    begin
        ctl1_next = in_ctl;
        for (int i = 0; i < 3; i++)
        begin
            sum1[i]    = {lane_in[i][COORD_WIDTH-1], lane_in[i]}
                       + {lane_off[i][COORD_WIDTH-1], lane_off[i]};
            sat1[i]    = sat_sum(sum1[i]);
            v1_next[i] = sat1[i][COORD_WIDTH-1:0];
            ctl1_next.ovf = ctl1_next.ovf | sat1[i][COORD_WIDTH];
        end
    end

    // stage 2: scale products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            p2_next[i] = v1_reg[i] * lane_fac[i];
    end

    // stage 3: floor by 2^8 and saturate
    always_comb
    begin
        ctl3_next = ctl2_reg;
        for (int i = 0; i < 3; i++)
        begin
            sat3[i]    = sat_prod(p2_reg[i][PW-1:vrts_pkg::FACTOR_FRAC]);
            v3_next[i] = sat3[i][COORD_WIDTH-1:0];
            ctl3_next.ovf = ctl3_next.ovf | sat3[i][COORD_WIDTH];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else
        begin
            if (en1)
                ctl1_reg <= ctl1_next;
            if (en2)
                ctl2_reg <= ctl1_reg;
            if (en3)
                ctl3_reg <= ctl3_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (en1)
                v1_reg[i] <= v1_next[i];
            if (en2)
                p2_reg[i] <= p2_next[i];
            if (en3)
                v3_reg[i] <= v3_next[i];
        end
    end

    assign out_ctl = ctl3_reg;
    assign out_x   = v3_reg[0];
    assign out_y   = v3_reg[1];
    assign out_z   = v3_reg[2];

    // the product stage holds its item while the output stage is blocked
    a_stage2_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl2_reg.valid && !en3) |=> ctl2_reg.valid)
        else $error("product stage dropped an item under stall");

endmodule

[hw/rtl/vertex_rotate_translate_scale.sv]
`timescale 1ns / 1ps

// pipeline: 3 rotations of 2 stages, then offset, multiply and floor/saturate stages
// throughput: one item per cycle while m_axis_tready is high; a stage stalls only when
//   it and all later stages are full and m_axis_tready is low, so bubbles collapse and
//   the input is taken while results wait
// reset: rst_n clears all stage valid bits and loads the identity rotations,
//   zero offsets and unit scales

module vertex_rotate_translate_scale #(
    parameter int COORD_WIDTH = 32,
    localparam int TDATA_WIDTH = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [TDATA_WIDTH-1:0]                  s_axis_tdata,   // in_x, in_y, in_z
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [TDATA_WIDTH-1:0]                  m_axis_tdata,   // out_x, out_y, out_z
    output logic                                    m_axis_tuser,   // overflow
    input  logic                                    cfg_wr_en,
    input  logic [vrts_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [vrts_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);

    localparam int W = COORD_WIDTH;

    logic [vrts_pkg::ROT_WIDTH-1:0]   rot_x_reg;
    logic [vrts_pkg::ROT_WIDTH-1:0]   rot_y_reg;
    logic [vrts_pkg::ROT_WIDTH-1:0]   rot_z_reg;
    logic [W-1:0]                     offset_x_reg;
    logic [W-1:0]                     offset_y_reg;
    logic [W-1:0]                     offset_z_reg;
    logic [vrts_pkg::SCALE_WIDTH-1:0] scale_reg;

    vrts_pkg::ctl_t          in_ctl;
    vrts_pkg::ctl_t          rx_ctl;
    vrts_pkg::ctl_t          ry_ctl;
    vrts_pkg::ctl_t          rz_ctl;
    vrts_pkg::ctl_t          os_ctl;
    logic                    rx_ready;
    logic                    ry_ready;
    logic                    rz_ready;
    logic                    os_ready;
    logic signed [W-1:0]     in_x;
    logic signed [W-1:0]     in_y;
    logic signed [W-1:0]     in_z;
    logic signed [W-1:0]     rx_x;
    logic signed [W-1:0]     rx_y;
    logic signed [W-1:0]     rx_z;
    logic signed [W-1:0]     ry_x;
    logic signed [W-1:0]     ry_y;
    logic signed [W-1:0]     ry_z;
    logic signed [W-1:0]     rz_x;
    logic signed [W-1:0]     rz_y;
    logic signed [W-1:0]     rz_z;
    logic signed [W-1:0]     os_x;
    logic signed [W-1:0]     os_y;
    logic signed [W-1:0]     os_z;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_x_reg    <= vrts_pkg::ROT_RESET;
            rot_y_reg    <= vrts_pkg::ROT_RESET;
            rot_z_reg    <= vrts_pkg::ROT_RESET;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            offset_z_reg <= '0;
            scale_reg    <= vrts_pkg::SCALE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                vrts_pkg::REG_ROT_X:    rot_x_reg    <= cfg_data[vrts_pkg::ROT_WIDTH-1:0];
                vrts_pkg::REG_ROT_Y:    rot_y_reg    <= cfg_data[vrts_pkg::ROT_WIDTH-1:0];
                vrts_pkg::REG_ROT_Z:    rot_z_reg    <= cfg_data[vrts_pkg::ROT_WIDTH-1:0];
                vrts_pkg::REG_OFFSET_X: offset_x_reg <= cfg_data[W-1:0];
                vrts_pkg::REG_OFFSET_Y: offset_y_reg <= cfg_data[W-1:0];
                vrts_pkg::REG_OFFSET_Z: offset_z_reg <= cfg_data[W-1:0];
                vrts_pkg::REG_SCALE:    scale_reg    <= cfg_data[vrts_pkg::SCALE_WIDTH-1:0];
                default:                ;
            endcase
        end
    end

    // input unpack
    assign in_x       = s_axis_tdata[W-1:0];
    assign in_y       = s_axis_tdata[2*W-1:W];
    assign in_z       = s_axis_tdata[3*W-1:2*W];
    assign in_ctl.valid = s_axis_tvalid;
    assign in_ctl.ovf   = 1'b0;
    assign s_axis_tready = rx_ready;

    // rotation about x: (y, z)
    vrts_rotate #(
        .COORD_WIDTH (W)
    ) u_rot_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .cos_sin   (rot_x_reg),
        .in_ctl    (in_ctl),
        .in_ready  (rx_ready),
        .in_a      (in_y),
        .in_b      (in_z),
        .in_c      (in_x),
        .out_ctl   (rx_ctl),
        .out_ready (ry_ready),
        .out_a     (rx_y),
        .out_b     (rx_z),
        .out_c     (rx_x)
    );

    // rotation about y: (z, x)
    vrts_rotate #(
        .COORD_WIDTH (W)
    ) u_rot_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .cos_sin   (rot_y_reg),
        .in_ctl    (rx_ctl),
        .in_ready  (ry_ready),
        .in_a      (rx_z),
        .in_b      (rx_x),
        .in_c      (rx_y),
        .out_ctl   (ry_ctl),
        .out_ready (rz_ready),
        .out_a     (ry_z),
        .out_b     (ry_x),
        .out_c     (ry_y)
    );

    // rotation about z: (x, y)
    vrts_rotate #(
        .COORD_WIDTH (W)
    ) u_rot_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .cos_sin   (rot_z_reg),
        .in_ctl    (ry_ctl),
        .in_ready  (rz_ready),
        .in_a      (ry_x),
        .in_b      (ry_y),
        .in_c      (ry_z),
        .out_ctl   (rz_ctl),
        .out_ready (os_ready),
        .out_a     (rz_x),
        .out_b     (rz_y),
        .out_c     (rz_z)
    );

    // translate and scale
    vrts_offset_scale #(
        .COORD_WIDTH (W)
    ) u_offset_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .offset_x  (offset_x_reg),
        .offset_y  (offset_y_reg),
        .offset_z  (offset_z_reg),
        .scale_xyz (scale_reg),
        .in_ctl    (rz_ctl),
        .in_ready  (os_ready),
        .in_x      (rz_x),
        .in_y      (rz_y),
        .in_z      (rz_z),
        .out_ctl   (os_ctl),
        .out_ready (m_axis_tready),
        .out_x     (os_x),
        .out_y     (os_y),
        .out_z     (os_z)
    );

    // output pack
    assign m_axis_tvalid = os_ctl.valid;
    assign m_axis_tdata  = TDATA_WIDTH'({os_z, os_y, os_x});
    assign m_axis_tuser  = os_ctl.ovf;

    // an empty or draining output stage lets the whole chain move
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("input stalled while the pipeline can advance");

    // nothing comes out right after reset
    a_empty_after_reset: assert property (@(posedge clk)
        (rst_n && !$past(rst_n)) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule
